FILE: rtl/rcn_pkg.sv
// ----------------------------------------------------------------------------
// rcn_pkg
// Shared widths, register indexes, reset values and unit status type for the
// RC channel normalizer.
// ----------------------------------------------------------------------------
package rcn_pkg;

  // datapath widths
  localparam int unsigned PW_W   = 16;  // pulse width, window edges
  localparam int unsigned LV_W   = 15;  // logical range values
  localparam int unsigned AX_W   = 16;  // axis value
  localparam int unsigned PROD_W = PW_W + LV_W;  // |x - pmin| * |lmax - lmin|
  localparam int unsigned QUO_W  = 16;  // quotient bits developed
  localparam int unsigned CNT_W  = 4;   // step counter of the serial units

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_CEILING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MAP    = 3'd6;

  // reset values
  localparam logic [PW_W-1:0]       RST_PULSE_MIN   = 16'd1000;
  localparam logic [PW_W-1:0]       RST_PULSE_MAX   = 16'd2000;
  localparam logic [LV_W-1:0]       RST_LOGICAL_MIN = 15'd0;
  localparam logic [LV_W-1:0]       RST_LOGICAL_MAX = 15'd2047;
  localparam logic [AX_W-1:0]       RST_AUX_FLOOR   = 16'd204;
  localparam logic [AX_W-1:0]       RST_AUX_CEILING = 16'd1844;
  localparam logic [CFG_DATA_W-1:0] RST_SLOT_MAP    = 24'd0;
  localparam logic [AX_W-1:0]       RST_AUX_AXIS    = 16'd1023;

  // item kinds
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_ENCODER = 1'b1;
  localparam logic KIND_CHAN  = 1'b0;
  localparam logic KIND_AUX   = 1'b1;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, result valid from then on
  } unit_stat_t;

endpackage

FILE: rtl/rc_channel_normalizer_core.sv
// ----------------------------------------------------------------------------
// rc_channel_normalizer_core
// Maps RC pulse widths to joystick axis values and tracks an encoder axis.
// ----------------------------------------------------------------------------
// A sample beat (tuser 0) carries a channel and a pulse width; a width outside
// [pulse_min, pulse_max] is replaced by the window midpoint, then mapped as
// (w - pulse_min) * (logical_max - logical_min) / (pulse_max - pulse_min)
// + logical_min, truncated toward zero, and sent to the slot that slot_map
// gives for the channel. An empty window yields logical_min; a channel at or
// beyond NUM_CHANNELS yields no result beat. An encoder beat (tuser 1) adds
// ten times the signed 16-bit count change to the aux axis, clamped to
// [aux_floor, aux_ceiling] (ceiling checked first), and passes the switches
// through. A sample runs operand prep, the bit-serial multiplier (15 steps)
// and the restoring divider (16 steps) back to back, each unit after its own
// start, then the hand-off out of the divider and the output load; an empty
// window skips both units and goes from prep to the output load. An encoder
// beat goes straight to the output load. One item is in work at a time; the
// next is accepted once the current one has moved into the output register,
// even while that result still waits for m_axis_tready. Config writes are
// taken in any cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module rc_channel_normalizer_core #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [rcn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] channel, [18:3] pulse_width, [34:19] encoder_count,
  // [42:35] switches, [47:43] zero
  input  logic [47:0]                    s_axis_tdata,
  // [0] opcode
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] slot, [18:3] axis_value, [26:19] buttons, [31:27] zero
  output logic [31:0]                    m_axis_tdata,
  // [0] kind
  output logic                           m_axis_tuser
);
  import rcn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_ENC
  } state_e;

  // ---------------------------------------------------------------- config
  logic [PW_W-1:0]       pmin_q, pmax_q;
  logic [LV_W-1:0]       lmin_q, lmax_q;
  logic [AX_W-1:0]       floor_q, ceil_q;
  logic [CFG_DATA_W-1:0] smap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q  <= RST_PULSE_MIN;
      pmax_q  <= RST_PULSE_MAX;
      lmin_q  <= RST_LOGICAL_MIN;
      lmax_q  <= RST_LOGICAL_MAX;
      floor_q <= RST_AUX_FLOOR;
      ceil_q  <= RST_AUX_CEILING;
      smap_q  <= RST_SLOT_MAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PULSE_MIN:   pmin_q  <= cfg_data_i[PW_W-1:0];
        CFG_PULSE_MAX:   pmax_q  <= cfg_data_i[PW_W-1:0];
        CFG_LOGICAL_MIN: lmin_q  <= cfg_data_i[LV_W-1:0];
        CFG_LOGICAL_MAX: lmax_q  <= cfg_data_i[LV_W-1:0];
        CFG_AUX_FLOOR:   floor_q <= cfg_data_i[AX_W-1:0];
        CFG_AUX_CEILING: ceil_q  <= cfg_data_i[AX_W-1:0];
        CFG_SLOT_MAP:    smap_q  <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  logic [2:0]      in_chan;
  logic [PW_W-1:0] in_pw, in_cnt;
  logic [7:0]      in_sw;
  logic            in_fire, chan_ok;

  assign in_chan = s_axis_tdata[2:0];
  assign in_pw   = s_axis_tdata[18:3];
  assign in_cnt  = s_axis_tdata[34:19];
  assign in_sw   = s_axis_tdata[42:35];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign chan_ok = {1'b0, in_chan} < 4'(NUM_CHANNELS);

  // ---------------------------------------------------------------- regs
  state_e          state_q;
  logic [2:0]      slot_q;
  logic [PW_W-1:0] pw_q, cnt_q;
  logic [7:0]      sw_q;
  logic [PW_W-1:0] last_q;
  logic [AX_W-1:0] aux_q;

  logic [PW_W-1:0] amag_q, dmag_q;
  logic [LV_W-1:0] lmag_q;
  logic            qneg_q;
  logic            mul_start_q, div_start_q;

  logic            m_valid_q, m_kind_q;
  logic [2:0]      m_slot_q;
  logic [AX_W-1:0] m_value_q;
  logic [7:0]      m_btn_q;

  logic out_free, out_load;
  assign out_free = !m_valid_q || m_axis_tready;
  // a new result enters the output register this cycle
  assign out_load = out_free && (state_q == ST_FIN || state_q == ST_ENC);

  // ---------------------------------------------------------------- prep
  // Sign/magnitude split of the mapping terms. |x - pmin| <= |den| in every
  // window shape, so |quotient| <= |lmax - lmin| and fits QUO_W bits.
  logic            in_win, den_zero;
  logic [PW_W:0]   mid_sum, a_s, den_s;
  logic [PW_W-1:0] x_w;
  logic [AX_W-1:0] lr_s;

  assign in_win   = (pw_q >= pmin_q) && (pw_q <= pmax_q);
  assign mid_sum  = {1'b0, pmin_q} + {1'b0, pmax_q};
  assign x_w      = in_win ? pw_q : mid_sum[PW_W:1];
  assign a_s      = {1'b0, x_w} - {1'b0, pmin_q};
  assign den_s    = {1'b0, pmax_q} - {1'b0, pmin_q};
  assign lr_s     = {1'b0, lmax_q} - {1'b0, lmin_q};
  assign den_zero = pmin_q == pmax_q;

  logic [PW_W:0]   a_neg, den_neg;
  logic [AX_W-1:0] lr_neg;
  assign a_neg   = -a_s;
  assign den_neg = -den_s;
  assign lr_neg  = -lr_s;

  // ---------------------------------------------------------------- units
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  unit_stat_t        mul_stat, div_stat;

  rcn_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (amag_q),
    .b_i     (lmag_q),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  rcn_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (prod),
    .den_i   (dmag_q),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  logic [AX_W-1:0] quo_s, map_val;
  assign quo_s   = qneg_q ? -quo : quo;
  assign map_val = {1'b0, lmin_q} + quo_s;

  // ---------------------------------------------------------------- encoder
  // 10 * diff as (diff << 3) + (diff << 1), 21-bit signed sum
  localparam int unsigned SUM_W = AX_W + 5;
  logic [PW_W-1:0]  enc_d;
  logic             enc_nz;
  logic [SUM_W-1:0] diff_x, step10, enc_sum;
  logic [AX_W-1:0]  aux_new;

  assign enc_d   = cnt_q - last_q;
  assign enc_nz  = enc_d != '0;
  assign diff_x  = {{(SUM_W-PW_W){enc_d[PW_W-1]}}, enc_d};
  assign step10  = (diff_x << 3) + (diff_x << 1);
  assign enc_sum = {{(SUM_W-AX_W){1'b0}}, aux_q} + step10;

  always_comb begin
    if ($signed(enc_sum) > $signed({{(SUM_W-AX_W){1'b0}}, ceil_q})) begin
      aux_new = ceil_q;
    end else if ($signed(enc_sum) < $signed({{(SUM_W-AX_W){1'b0}}, floor_q})) begin
      aux_new = floor_q;
    end else begin
      aux_new = enc_sum[AX_W-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      last_q      <= '0;
      aux_q       <= RST_AUX_AXIS;
      m_valid_q   <= 1'b0;
      m_kind_q    <= KIND_CHAN;
      m_slot_q    <= '0;
      m_value_q   <= '0;
      m_btn_q     <= '0;
      slot_q      <= '0;
      pw_q        <= '0;
      cnt_q       <= '0;
      sw_q        <= '0;
      amag_q      <= '0;
      dmag_q      <= '0;
      lmag_q      <= '0;
      qneg_q      <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pw_q   <= in_pw;
            cnt_q  <= in_cnt;
            sw_q   <= in_sw;
            slot_q <= smap_q[3*in_chan +: 3];
            if (s_axis_tuser == OP_ENCODER) begin
              state_q <= ST_ENC;
            end else if (chan_ok) begin
              state_q <= ST_PREP;
            end
            // sample on an absent channel: dropped, no beat out
          end
        end
        ST_PREP: begin
          amag_q <= a_s[PW_W] ? a_neg[PW_W-1:0] : a_s[PW_W-1:0];
          dmag_q <= den_s[PW_W] ? den_neg[PW_W-1:0] : den_s[PW_W-1:0];
          lmag_q <= lr_s[AX_W-1] ? lr_neg[LV_W-1:0] : lr_s[LV_W-1:0];
          qneg_q <= !den_zero && (a_s[PW_W] ^ den_s[PW_W] ^ lr_s[AX_W-1]);
          if (den_zero) begin
            // empty window: value is logical_min, both units skipped
            state_q <= ST_FIN;
          end else begin
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= KIND_CHAN;
            m_slot_q  <= slot_q;
            m_value_q <= den_zero ? {1'b0, lmin_q} : map_val;
            m_btn_q   <= '0;
            state_q   <= ST_IDLE;
          end
        end
        ST_ENC: begin
          if (out_free) begin
            if (enc_nz) begin
              aux_q  <= aux_new;
              last_q <= cnt_q;
            end
            m_valid_q <= 1'b1;
            m_kind_q  <= KIND_AUX;
            m_slot_q  <= '0;
            m_value_q <= enc_nz ? aux_new : aux_q;
            m_btn_q   <= sw_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {5'b0, m_btn_q, m_value_q, m_slot_q};

`ifndef SYNTHESIS
  // the two serial units never overlap
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // unit completions only arrive in the state waiting for them
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> state_q == ST_MUL)
    else $error("multiplier done outside multiply phase");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider done outside divide phase");

  // aux beats carry slot zero, channel beats carry no buttons
  a_out_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_kind_q == KIND_AUX) ? (m_slot_q == '0) : (m_btn_q == '0))
    else $error("result beat carries a field of the other kind");

  // a clamped update with ordered limits lands inside them
  a_aux_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENC && out_free && enc_nz && floor_q <= ceil_q)
    |=> (aux_q >= $past(floor_q) && aux_q <= $past(ceil_q)))
    else $error("aux axis outside its limits after update");
`endif

endmodule

FILE: rtl/rcn_serial_mul.sv
// ----------------------------------------------------------------------------
// rcn_serial_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rcn_serial_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rcn_pkg::PW_W-1:0]   a_i,
  input  logic [rcn_pkg::LV_W-1:0]   b_i,
  output logic [rcn_pkg::PROD_W-1:0] prod_o,
  output rcn_pkg::unit_stat_t        stat_o
);
  import rcn_pkg::*;

  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [PW_W-1:0]   a_q;
  logic [PROD_W-1:0] p_q;
  logic [PW_W:0]     sum;

  // upper half accumulates, lower half holds the remaining multiplier bits
  assign sum = {1'b0, p_q[PROD_W-1:LV_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{PW_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[LV_W-1:1]};
    end
  end

  assign prod_o      = p_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/rcn_serial_div.sv
// ----------------------------------------------------------------------------
// rcn_serial_div
// Restoring divider, one quotient bit per cycle. Caller guarantees the
// quotient fits QUO_W bits (dividend < divisor * 2**QUO_W).
// ----------------------------------------------------------------------------
module rcn_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rcn_pkg::PROD_W-1:0] num_i,
  input  logic [rcn_pkg::PW_W-1:0]   den_i,
  output logic [rcn_pkg::QUO_W-1:0]  quo_o,
  output rcn_pkg::unit_stat_t        stat_o
);
  import rcn_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [PW_W-1:0]  d_q;
  logic [PW_W-1:0]  rem_q;
  logic [QUO_W-1:0] q_q;
  logic [PW_W:0]    trial, diff;
  logic             ge;

  assign trial = {rem_q, q_q[QUO_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= den_i;
      rem_q <= {1'b0, num_i[PROD_W-1:QUO_W]};
      q_q   <= num_i[QUO_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[PW_W-1:0] : trial[PW_W-1:0];
      q_q   <= {q_q[QUO_W-2:0], ge};
    end
  end

  assign quo_o       = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
